[hw/rtl/tcw_pkg.sv]
// Shared types, geometry constants and codes for the text console writer.
package tcw_pkg;

   // Screen geometry.
   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int COPY_COUNT  = COLUMNS * (ROWS - 1);
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int COL_W       = $clog2(COLUMNS);
   localparam int ROW_W       = $clog2(ROWS);

   // Field widths of the request and response.
   localparam int OP_W        = 2;
   localparam int CHAR_W      = 8;
   localparam int COLOUR_W    = 4;
   localparam int INDEX_W     = 11;
   localparam int CUR_COL_W   = 7;
   localparam int CUR_ROW_W   = 5;
   localparam int CELL_W      = 16;

   // Operation codes. The last code is unused and leaves everything unchanged.
   localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Character codes and colours.
   localparam logic [CHAR_W-1:0]   CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0]   CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0]   CHAR_BLANK   = 8'h20;
   localparam logic [CHAR_W-1:0]   PRINT_MIN    = 8'h20;
   localparam logic [CHAR_W-1:0]   PRINT_MAX    = 8'h7F;
   localparam logic [COLOUR_W-1:0] COLOUR_WHITE = 4'hF;
   localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 4'h0;
   localparam int                  TAB_STEP     = 8;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [CHAR_W-1:0]   char_code;
      logic [COLOUR_W-1:0] fore_colour;
      logic [COLOUR_W-1:0] back_colour;
      logic [INDEX_W-1:0]  cell_index;
   } req_type;

   typedef struct packed {
      logic [CUR_COL_W-1:0] cursor_col;
      logic [CUR_ROW_W-1:0] cursor_row;
      logic                 scrolled;
      logic [CELL_W-1:0]    cell_value;
   } rsp_type;

   typedef enum logic [1:0] {
      SWEEP_NONE,
      SWEEP_FILL,
      SWEEP_COPY
   } sweep_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic      capture;
      logic      put;
      logic      home;
      logic      fill_black;
      logic      load_rsp;
      sweep_type sweep;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_scroll;
      logic copy_last;
      logic fill_last;
   } dp_status_type;

endpackage

[hw/rtl/tcw_datapath.sv]
// Datapath of the text console writer: cursor, screen memory, sweep counter, response.
module tcw_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::req_type       req_payload,
   input  tcw_pkg::dp_cmd_type    cmd,
   output tcw_pkg::dp_status_type status,
   output tcw_pkg::rsp_type       rsp_payload
);
   import tcw_pkg::*;

   // Captured request fields.
   logic [CHAR_W-1:0]   char_ff;
   logic [COLOUR_W-1:0] fore_ff;
   logic [COLOUR_W-1:0] back_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                read_ff;

   // Cursor and sweep control.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              copy_pend_ff;
   logic [ADDR_W-1:0] copy_waddr_ff;
   logic              scrolled_ff;

   // Screen memory.
   logic [CELL_W-1:0] mem_ff [CELL_COUNT];
   logic [CELL_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   rsp_type rsp_ff;

   // Put arithmetic.
   logic [COL_W:0]    col_step;
   logic [COL_W:0]    col_wide;
   logic [ROW_W:0]    row_wide;
   logic              printable;
   logic              need_scroll;
   logic              index_ok;
   logic [ADDR_W-1:0] cell_pos;
   logic [CELL_W-1:0] fill_cell;

   always_comb begin
      col_step  = {1'b0, col_ff};
      row_wide  = {1'b0, row_ff};
      printable = (char_ff >= PRINT_MIN) && (char_ff <= PRINT_MAX);
      if (char_ff == CHAR_NEWLINE) begin
         col_step = '0;
         row_wide = row_wide + 1'b1;
      end else if (char_ff == CHAR_TAB) begin
         col_step = (col_step + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
      end else if (printable) begin
         col_step = col_step + 1'b1;
      end
      col_wide = col_step;
      if (col_step >= (COL_W+1)'(COLUMNS)) begin
         col_wide = '0;
         row_wide = row_wide + 1'b1;
      end
      need_scroll = (row_wide >= (ROW_W+1)'(ROWS));
   end

   assign cell_pos  = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);
   assign index_ok  = (32'(index_ff) < CELL_COUNT);
   assign fill_cell = {(cmd.fill_black ? COLOUR_BLACK : back_ff), COLOUR_WHITE, CHAR_BLANK};

   // One write port: pending scroll copy first, then sweep fill, then a printed cell.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cell_pos;
      mem_wdata = {back_ff, fore_ff, char_ff};
      if (copy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_waddr_ff;
         mem_wdata = rd_data_ff;
      end else if (cmd.sweep == SWEEP_FILL) begin
         mem_we    = 1'b1;
         mem_waddr = cnt_ff;
         mem_wdata = fill_cell;
      end else if (cmd.put && printable) begin
         mem_we    = 1'b1;
      end
   end

   always_comb begin
      if (cmd.sweep == SWEEP_COPY) begin
         mem_raddr = cnt_ff + ADDR_W'(COLUMNS);
      end else if (index_ok) begin
         mem_raddr = ADDR_W'(index_ff);
      end else begin
         mem_raddr = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   always_comb begin
      case (cmd.sweep)
         SWEEP_FILL: cnt_in = status.fill_last ? '0 : cnt_ff + 1'b1;
         SWEEP_COPY: cnt_in = cnt_ff + 1'b1;
         default:    cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.home) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.put) begin
         col_in = col_wide[COL_W-1:0];
         row_in = need_scroll ? ROW_W'(ROWS - 1) : row_wide[ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         copy_pend_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         copy_pend_ff <= (cmd.sweep == SWEEP_COPY);
      end
   end

   always_ff @(posedge clock) begin
      copy_waddr_ff <= cnt_ff;
      if (cmd.capture) begin
         char_ff     <= req_payload.char_code;
         fore_ff     <= req_payload.fore_colour;
         back_ff     <= req_payload.back_colour;
         index_ff    <= req_payload.cell_index;
         read_ff     <= (req_payload.operation == OP_READ);
         scrolled_ff <= 1'b0;
      end else if (cmd.put) begin
         scrolled_ff <= need_scroll;
      end
      if (cmd.load_rsp) begin
         rsp_ff.cursor_col <= CUR_COL_W'(col_ff);
         rsp_ff.cursor_row <= CUR_ROW_W'(row_ff);
         rsp_ff.scrolled   <= scrolled_ff;
         rsp_ff.cell_value <= (read_ff && index_ok) ? rd_data_ff : '0;
      end
   end

   assign status.need_scroll = need_scroll;
   assign status.copy_last   = (cnt_ff == ADDR_W'(COPY_COUNT - 1));
   assign status.fill_last   = (cnt_ff == ADDR_W'(CELL_COUNT - 1));
   assign rsp_payload        = rsp_ff;

endmodule

[hw/rtl/tcw_ctrl.sv]
// Controller state machine of the text console writer.
module tcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [tcw_pkg::OP_W-1:0] req_op,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tcw_pkg::dp_status_type status,
   output tcw_pkg::dp_cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_CLEAR,
      ST_READ,
      ST_COPY,
      ST_DRAIN,
      ST_FILL_ROW,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{default: '0, sweep: SWEEP_NONE};
      case (state_ff)
         ST_INIT: begin
            cmd.sweep      = SWEEP_FILL;
            cmd.fill_black = 1'b1;
            cmd.home       = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_op)
                  OP_PUT:   state_in = ST_PUT;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_READ:  state_in = ST_READ;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_PUT: begin
            cmd.put  = 1'b1;
            state_in = status.need_scroll ? ST_COPY : ST_DONE;
         end
         ST_CLEAR: begin
            cmd.sweep = SWEEP_FILL;
            cmd.home  = 1'b1;
            if (status.fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_COPY: begin
            cmd.sweep = SWEEP_COPY;
            if (status.copy_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FILL_ROW;
         end
         ST_FILL_ROW: begin
            cmd.sweep = SWEEP_FILL;
            if (status.fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/text_console_writer_top.sv]
// Top level of the text console writer: an 80 by 25 text screen with cursor handling.
//
// Each request puts a character, clears the screen or reads one cell, and gives exactly one
// response with the cursor after the request, a scroll flag and, for a read, the cell value.
// The screen lives in a single memory of 2000 16-bit cells with one write and one registered
// read per cycle, and that port sets the timing. A put or a read goes from the idle state
// through its own state to the done state, which loads the response register. A put that
// runs off the bottom row scrolls the screen: the copy of rows 1 to 24 up by one row goes one
// cell per cycle through the memory port, then the new bottom row is filled. A clear writes
// every cell once. After reset the block sweeps the memory to load white blanks on black, and
// holds off requests until that sweep is done. A finished response waits in an output
// register, so the next request can already be accepted.
module text_console_writer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_payload
);
   import tcw_pkg::*;

   // Command and status between the controller and the datapath.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The controller sequences each request and owns both handshakes.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.operation),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the cursor, the screen memory and the response register.
   tcw_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[hw/rtl/tcw_checker.sv]
// Port-level checker for the text console writer and its bind to the top level.
module tcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tcw_pkg::rsp_type rsp_payload
);
   import tcw_pkg::*;

   // The memory sweep after reset keeps requests out.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request accepted during the reset sweep");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // The cursor shown is always on the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_payload.cursor_col) < COLUMNS
                     && 32'(rsp_payload.cursor_row) < ROWS))
      else $error("cursor off the screen");

   // A scroll leaves the cursor on the bottom row, and a put never returns cell data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.scrolled) |->
         (32'(rsp_payload.cursor_row) == ROWS - 1 && rsp_payload.cell_value == '0))
      else $error("scroll response inconsistent");

endmodule

bind text_console_writer_top tcw_checker u_checker (.*);
